// File: rtl/fefg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect package
// Shared widths, reset values and the raster flag bundle of the fire effect.
// ----------------------------------------------------------------------------
package fefg_pkg;

	// Default store geometry.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 768;

	// Configuration register widths and reset values.
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 10;
	localparam int CFG_DATA_W     = 11;
	localparam logic [FRAME_WIDTH_W-1:0]  RESET_WIDTH  = 11'd800;
	localparam logic [FRAME_HEIGHT_W-1:0] RESET_HEIGHT = 10'd600;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Smallest usable width or height.
	localparam int MIN_DIM = 4;

	// Buffer rows at the bottom that take noise instead of the stencil.
	localparam int BOTTOM_ROWS = 3;

	// Heat cell and colour component widths.
	localparam int HEAT_W  = 8;
	localparam int NOISE_W = 4;
	localparam int COLOR_W = 8;

	// Per-pixel raster flags handed from the position counters to the datapath.
	typedef struct packed {
		logic bottom;   // pixel lies in one of the bottom buffer rows
		logic eof;      // last pixel of the frame
	} pos_flags_t;

endpackage

// File: rtl/fire_effect_frame_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect frame generator
// Classic fire effect: heat store update and palette lookup per raster pixel.
// ----------------------------------------------------------------------------
// Feed one transfer per displayed pixel in raster order (top row first, left
// to right) carrying the noise for that pixel; each input transfer yields one
// output transfer with the pixel's colour, and tlast marks the last pixel of
// a frame. The block sustains one pixel per clock unless the output stalls:
// the four stencil reads of a pixel are served together by two identical
// copies of the heat store, each with one write port and two read ports, and
// the result of a pixel is written back while the next pixel's reads are
// issued, with forwarding where the two meet. A pixel passes the stage 1, 2
// and 3 registers before the output register. After reset the block walks
// the whole store writing zeros, one cell per clock, over MAX_WIDTH *
// MAX_HEIGHT cells (786432 with the default geometry); s_axis_tready stays
// low for that pass, while the configuration port is served as always.
// Change frame_width or frame_height only while no pixel is in flight.
// ----------------------------------------------------------------------------
module fire_effect_frame_generator #(
	parameter int MAX_WIDTH  = fefg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fefg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration writes: index 0 frame_width, index 1 frame_height.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [fefg_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Pixel input stream.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,   // noise_amount [3:0]
	// Colour output stream.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [23:0]                      m_axis_tdata,   // red, green, blue
	output logic                             m_axis_tlast    // end_of_frame
);
	import fefg_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int SUM_W  = 11;   // holds 7 * 255
	localparam int COOL_W = 16;   // holds 7 * 255 * 36
	localparam int NPORTS = 4;

	// Configuration registers.
	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;

	// Clearing pass after reset.
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// Raster position of the pixel being accepted.
	logic [WW-1:0] width_used;
	logic [CW-1:0] col;
	logic [RW-1:0] buf_row;
	pos_flags_t    flags;

	// Pipeline control.
	logic accept;
	logic adv1;
	logic adv2;
	logic adv3;
	logic s1_free;
	logic s2_free;
	logic s3_free;
	logic out_ready;
	logic v_s1;
	logic v_s2;
	logic v_s3;

	// Stage 1: raster position.
	logic [CW-1:0]      col_s1;
	logic [RW-1:0]      row_s1;
	pos_flags_t         flags_s1;
	logic [NOISE_W-1:0] noise_s1;

	// Stage 2: flat cell address, reads issued.
	logic [AW-1:0]      p_s2;
	pos_flags_t         flags_s2;
	logic [NOISE_W-1:0] noise_s2;

	// Stage 3: read data back, cell computed and written.
	logic [AW-1:0]      p_s3;
	pos_flags_t         flags_s3;
	logic [NOISE_W-1:0] noise_s3;
	logic [NPORTS-1:0]  hit_s3;
	logic [HEAT_W-1:0]  fwd_heat_s3;
	logic [HEAT_W-1:0]  cell_s3;

	logic [AW-1:0]      w_ext;
	logic [AW-1:0]      w2;
	logic [AW-1:0]      rd_addr [NPORTS];
	logic [HEAT_W-1:0]  rd_heat [NPORTS];
	logic [HEAT_W-1:0]  heat_op [NPORTS];
	logic [SUM_W-1:0]   stencil_sum;
	logic [COOL_W-1:0]  cooled;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [HEAT_W-1:0]  mem_wdata;

	// ------------------------------------------------------------------------
	// Configuration port. Writes are always taken; an index outside the list
	// has no effect.
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_WIDTH;
			frame_height_q <= RESET_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Clearing pass: every cell of both store copies is set to zero before the
	// first pixel is taken.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Handshake chain. Each stage moves on when the stage after it is empty or
	// moving, so bubbles are filled even while the output register waits.
	// ------------------------------------------------------------------------
	assign s3_free       = !v_s3 || out_ready;
	assign s2_free       = !v_s2 || s3_free;
	assign s1_free       = !v_s1 || s2_free;
	assign adv3          = v_s3 && out_ready;
	assign adv2          = v_s2 && s3_free;
	assign adv1          = v_s1 && s2_free;
	assign s_axis_tready = s1_free && !clearing_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= accept;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Raster counters: the transfer position becomes a column and a buffer row.
	// ------------------------------------------------------------------------
	fefg_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.advance      (accept),
		.width_used   (width_used),
		.col          (col),
		.buf_row      (buf_row),
		.flags        (flags)
	);

	// ------------------------------------------------------------------------
	// Stage addresses. The flat address is buffer row times width plus column.
	// The stencil reads p-w, p-2w-1, p-2w and p-2w+1; a bottom-row pixel only
	// needs its own cell, so every port reads p then.
	// ------------------------------------------------------------------------
	assign w_ext = AW'(width_used);
	assign w2    = w_ext << 1;

	always_comb begin
		if (flags_s2.bottom) begin
			for (int k = 0; k < NPORTS; k++) begin
				rd_addr[k] = p_s2;
			end
		end else begin
			rd_addr[0] = p_s2 - w_ext;
			rd_addr[1] = p_s2 - w2 - AW'(1);
			rd_addr[2] = p_s2 - w2;
			rd_addr[3] = p_s2 - w2 + AW'(1);
		end
	end

	// Payload registers follow the valid bits and need no reset. A read that
	// is issued while the pixel ahead writes the same cell takes that pixel's
	// result from the forwarding register, since the store returns old data.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col;
			row_s1   <= buf_row;
			flags_s1 <= flags;
			noise_s1 <= s_axis_tdata[NOISE_W-1:0];
		end
		if (adv1) begin
			p_s2     <= AW'(row_s1) * w_ext + AW'(col_s1);
			flags_s2 <= flags_s1;
			noise_s2 <= noise_s1;
		end
		if (adv2) begin
			p_s3        <= p_s2;
			flags_s3    <= flags_s2;
			noise_s3    <= noise_s2;
			fwd_heat_s3 <= cell_s3;
			for (int k = 0; k < NPORTS; k++) begin
				hit_s3[k] <= adv3 && (rd_addr[k] == p_s3);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Heat store: two identical copies written together, two reads each.
	// ------------------------------------------------------------------------
	assign mem_we    = clearing_q || adv3;
	assign mem_waddr = clearing_q ? clr_addr_q : p_s3;
	assign mem_wdata = clearing_q ? '0 : cell_s3;

	fefg_heat_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_heat_mem0 (
		.clk       (clk),
		.we        (mem_we),
		.wr_addr   (mem_waddr),
		.wr_data   (mem_wdata),
		.re        (adv2),
		.rd_addr_a (rd_addr[0]),
		.rd_addr_b (rd_addr[1]),
		.rd_data_a (rd_heat[0]),
		.rd_data_b (rd_heat[1])
	);

	fefg_heat_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_heat_mem1 (
		.clk       (clk),
		.we        (mem_we),
		.wr_addr   (mem_waddr),
		.wr_data   (mem_wdata),
		.re        (adv2),
		.rd_addr_a (rd_addr[2]),
		.rd_addr_b (rd_addr[3]),
		.rd_data_a (rd_heat[2]),
		.rd_data_b (rd_heat[3])
	);

	// ------------------------------------------------------------------------
	// Cell update. Upper rows cool the weighted stencil by 36/256, computed as
	// a shift-and-add; bottom rows add the noise with wraparound.
	// ------------------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < NPORTS; k++) begin
			heat_op[k] = hit_s3[k] ? fwd_heat_s3 : rd_heat[k];
		end
		stencil_sum = SUM_W'(heat_op[0])
			+ ((SUM_W'(heat_op[1]) + SUM_W'(heat_op[2]) + SUM_W'(heat_op[3])) << 1);
		cooled = (COOL_W'(stencil_sum) << 5) + (COOL_W'(stencil_sum) << 2);
		if (flags_s3.bottom) begin
			cell_s3 = heat_op[0] + HEAT_W'(noise_s3);
		end else begin
			cell_s3 = cooled[COOL_W-1:COOL_W-HEAT_W];
		end
	end

	// ------------------------------------------------------------------------
	// Palette and output register.
	// ------------------------------------------------------------------------
	fefg_palette u_palette (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s3),
		.in_ready      (out_ready),
		.heat          (cell_s3),
		.eof           (flags_s3.eof),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------

	// The clearing pass owns the write port, so no pixel may be in flight.
	a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !(v_s1 || v_s2 || v_s3))
		else $error("pixel in flight during clearing pass");

	// A pixel write-back always lands inside the store.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 |-> (p_s3 <= AW'(DEPTH - 1)))
		else $error("heat write address beyond store depth");

	// A pixel leaving the last stage shows up in the output register.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 |=> m_axis_tvalid)
		else $error("written pixel did not reach the output register");

	// The clearing pass ends only after the last cell has been zeroed.
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_addr_q) == AW'(DEPTH - 1)))
		else $error("clearing pass ended early");

endmodule

// File: rtl/fefg_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect raster position
// Column and row counters, geometry clamping and buffer row generation.
// ----------------------------------------------------------------------------
module fefg_raster #(
	parameter int MAX_WIDTH  = fefg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fefg_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int WW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fefg_pkg::FRAME_WIDTH_W-1:0]  frame_width,
	input  logic [fefg_pkg::FRAME_HEIGHT_W-1:0] frame_height,
	input  logic                                advance,
	output logic [WW-1:0]                       width_used,
	output logic [CW-1:0]                       col,
	output logic [RW-1:0]                       buf_row,
	output fefg_pkg::pos_flags_t                flags
);
	import fefg_pkg::*;

	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0] column_count_q;
	logic [RW-1:0] row_count_q;
	logic [HW-1:0] height_used;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic [RW-1:0] row;
	logic          last_col;
	logic          last_row;

	// Out-of-range registers are clamped; the registers keep their bits.
	always_comb begin
		if (32'(frame_width) < 32'(MIN_DIM)) begin
			width_used = WW'(MIN_DIM);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			width_used = WW'(MAX_WIDTH);
		end else begin
			width_used = WW'(frame_width);
		end
		if (32'(frame_height) < 32'(MIN_DIM)) begin
			height_used = HW'(MIN_DIM);
		end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
			height_used = HW'(MAX_HEIGHT);
		end else begin
			height_used = HW'(frame_height);
		end
	end

	// A counter at or past the last column or row is taken as that last one.
	assign col_last = CW'(width_used - WW'(1));
	assign row_last = RW'(height_used - HW'(1));
	assign col      = (column_count_q < col_last) ? column_count_q : col_last;
	assign row      = (row_count_q < row_last) ? row_count_q : row_last;
	assign last_col = (col == col_last);
	assign last_row = (row == row_last);

	// Display row zero is the top of the screen, buffer row zero the bottom.
	assign buf_row      = row_last - row;
	assign flags.bottom = (buf_row < RW'(BOTTOM_ROWS));
	assign flags.eof    = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (advance) begin
			if (last_col) begin
				column_count_q <= '0;
				row_count_q    <= last_row ? '0 : row + RW'(1);
			end else begin
				column_count_q <= col + CW'(1);
				row_count_q    <= row;
			end
		end
	end

endmodule

// File: rtl/fefg_heat_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect heat memory
// One copy of the heat store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fefg_heat_mem #(
	parameter int DEPTH = fefg_pkg::DEF_MAX_WIDTH * fefg_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               wr_addr,
	input  logic [fefg_pkg::HEAT_W-1:0] wr_data,
	input  logic                        re,
	input  logic [AW-1:0]               rd_addr_a,
	input  logic [AW-1:0]               rd_addr_b,
	output logic [fefg_pkg::HEAT_W-1:0] rd_data_a,
	output logic [fefg_pkg::HEAT_W-1:0] rd_data_b
);
	import fefg_pkg::*;

	logic [HEAT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Reads return the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: rtl/fefg_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect palette and output register
// Maps a heat cell to its colour and holds the result for the output stream.
// ----------------------------------------------------------------------------
module fefg_palette (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fefg_pkg::HEAT_W-1:0] heat,
	input  logic                        eof,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [23:0]                 m_axis_tdata,   // red, green, blue
	output logic                        m_axis_tlast    // end_of_frame
);
	import fefg_pkg::*;

	// (255 - 2i) / 3, rounded toward zero, kept to eight bits. The division
	// by three is a multiply by 171 and a shift, exact for magnitudes below 256.
	function automatic logic [COLOR_W-1:0] green_of(input logic [HEAT_W-1:0] i);
		logic [8:0]         mag;
		logic [16:0]        prod;
		logic [COLOR_W-1:0] q;
		if (!i[HEAT_W-1]) begin
			mag = 9'd255 - {i, 1'b0};
		end else begin
			mag = {i, 1'b0} - 9'd255;
		end
		prod = 17'(mag) * 17'd171;
		q    = prod[16:9];
		return i[HEAT_W-1] ? COLOR_W'(-q) : q;
	endfunction

	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               tvalid_q;
	logic [23:0]        tdata_q;
	logic               tlast_q;

	assign red   = {heat[5:0], 2'b00};
	assign green = green_of(heat);
	assign blue  = heat + {heat[HEAT_W-2:0], 1'b0};

	assign in_ready = !tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (in_ready) begin
			tvalid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tdata_q <= {blue, green, red};
			tlast_q <= eof;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

endmodule
